// ===== hw/rtl/cdds_pkg.sv =====
package cdds_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int DAY_W       = 5;
  localparam int MONTH_W     = 4;
  localparam int YEAR_W      = 14;

  localparam logic [YEAR_W-1:0]  MAX_YEAR   = 14'd9999;
  localparam logic [YEAR_W-1:0]  FLOOR_YEAR = 14'd1900;
  localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_LAST   = 5'd31;

  // Year mod 100 and the century mod 4 are carried alongside the year.
  localparam logic [6:0] CENT_LAST  = 7'd99;
  // The floor year 1900 is century 19, which is 3 mod 4.
  localparam logic [1:0] FLOOR_C4   = 2'd3;

  // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y.
  localparam logic [12:0] RECIP100  = 13'd5243;
  localparam int          RECIP_SH  = 19;

  typedef struct packed {
    logic capture;
    logic load_apply;
    logic step_en;
    logic out_load;
  } cdds_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic at_limit;
  } cdds_sts_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      MONTH_FEB:                  n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    n = 5'd30;
      default:                    n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// ===== hw/rtl/calendar_date_day_stepper_core.sv =====
// Holds one Gregorian date (reset 1/1/1900). A load transaction (mode 0) sets
// the date from day, month and year, falling back to 1/1/1900 for an invalid
// date; an add transaction (mode 1) moves the date by a signed day count,
// pinning at 1/1/1900 going back and saturating at 31/12/9999 going forward,
// with limit_hit set when that happens. Each transaction returns the date that
// results. The date advances one day per clock through a single step unit, so
// an add runs for |offset| steps (fewer when a limit ends it early), and a
// load applies the captured date directly. Inputs are taken one at a
// time; a new transaction is accepted while the previous result waits.
module calendar_date_day_stepper_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_mode,
  input  logic [cdds_pkg::DAY_W-1:0]              in_load_day,
  input  logic [cdds_pkg::MONTH_W-1:0]            in_load_month,
  input  logic [cdds_pkg::YEAR_W-1:0]             in_load_year,
  input  logic signed [cdds_pkg::OFFSET_BITS-1:0] in_day_offset,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [cdds_pkg::DAY_W-1:0]              out_day_out,
  output logic [cdds_pkg::MONTH_W-1:0]            out_month_out,
  output logic [cdds_pkg::YEAR_W-1:0]             out_year_out,
  output logic                                    out_limit_hit
);
  import cdds_pkg::*;

  cdds_cmd_t cmd;
  cdds_sts_t sts;

  cdds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cdds_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_mode       (in_mode),
    .in_load_day   (in_load_day),
    .in_load_month (in_load_month),
    .in_load_year  (in_load_year),
    .in_day_offset (in_day_offset),
    .out_day_out   (out_day_out),
    .out_month_out (out_month_out),
    .out_year_out  (out_year_out),
    .out_limit_hit (out_limit_hit)
  );

endmodule

// ===== hw/rtl/cdds_ctrl.sv =====
module cdds_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_mode,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  cdds_pkg::cdds_sts_t sts,
  output cdds_pkg::cdds_cmd_t cmd
);
  import cdds_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_STEP = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = in_mode ? ST_STEP : ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_apply = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_STEP: begin
        if (sts.cnt_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.step_en = 1'b1;
          if (sts.at_limit) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // The result register may still hold the previous transaction.
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/cdds_datapath.sv =====
module cdds_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cdds_pkg::cdds_cmd_t                  cmd,
  output cdds_pkg::cdds_sts_t                  sts,
  input  logic                                 in_mode,
  input  logic [cdds_pkg::DAY_W-1:0]           in_load_day,
  input  logic [cdds_pkg::MONTH_W-1:0]         in_load_month,
  input  logic [cdds_pkg::YEAR_W-1:0]          in_load_year,
  input  logic signed [cdds_pkg::OFFSET_BITS-1:0] in_day_offset,
  output logic [cdds_pkg::DAY_W-1:0]           out_day_out,
  output logic [cdds_pkg::MONTH_W-1:0]         out_month_out,
  output logic [cdds_pkg::YEAR_W-1:0]          out_year_out,
  output logic                                 out_limit_hit
);
  import cdds_pkg::*;

  // Captured transaction.
  logic [DAY_W-1:0]       ld_day_r;
  logic [MONTH_W-1:0]     ld_month_r;
  logic [YEAR_W-1:0]      ld_year_r;
  logic [7:0]             ld_q_r;
  logic                   neg_r;
  logic [OFFSET_BITS-1:0] cnt_r;
  logic                   limit_r;

  // Current date with year mod 100 and century mod 4.
  logic [DAY_W-1:0]   day_r, day_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;
  logic [6:0]         r100_r, r100_nxt;
  logic [1:0]         c4_r, c4_nxt;

  logic [26:0]            prod;
  logic [YEAR_W-1:0]      rem_full;
  logic [6:0]             ld_r100;
  logic                   ld_leap;
  logic                   ld_ok;
  logic [OFFSET_BITS-1:0] mag;
  logic                   leap_cur;
  logic [DAY_W-1:0]       len_cur;
  logic [DAY_W-1:0]       len_prev;
  logic                   at_ceiling;
  logic                   at_floor;

  assign prod = 27'(in_load_year) * 27'(RECIP100);
  // Two's complement negate; the most negative offset reads as its magnitude.
  assign mag  = in_day_offset[OFFSET_BITS-1] ? (~in_day_offset + 1'b1) : in_day_offset;

  assign rem_full = ld_year_r - (YEAR_W'(ld_q_r) * 14'd100);
  assign ld_r100  = rem_full[6:0];
  assign ld_leap  = (ld_year_r[1:0] == 2'd0) && ((ld_r100 != 7'd0) || (ld_q_r[1:0] == 2'd0));
  assign ld_ok    = (ld_day_r != '0) && (ld_month_r != '0) && (ld_year_r != '0) &&
                    (ld_month_r <= MONTH_DEC) && (ld_year_r <= MAX_YEAR) &&
                    (ld_day_r <= month_len(ld_month_r, ld_leap));

  assign leap_cur   = (year_r[1:0] == 2'd0) && ((r100_r != 7'd0) || (c4_r == 2'd0));
  assign len_cur    = month_len(month_r, leap_cur);
  assign len_prev   = month_len(month_r - 1'b1, leap_cur);
  assign at_ceiling = (year_r >= MAX_YEAR) && (month_r >= MONTH_DEC) && (day_r >= DAY_LAST);
  assign at_floor   = (day_r <= DAY_FIRST) && (month_r <= MONTH_JAN) && (year_r <= FLOOR_YEAR);

  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.at_limit = neg_r ? at_floor : at_ceiling;

  always_comb begin
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    r100_nxt  = r100_r;
    c4_nxt    = c4_r;
    if (cmd.load_apply) begin
      if (ld_ok) begin
        day_nxt   = ld_day_r;
        month_nxt = ld_month_r;
        year_nxt  = ld_year_r;
        r100_nxt  = ld_r100;
        c4_nxt    = ld_q_r[1:0];
      end else begin
        day_nxt   = DAY_FIRST;
        month_nxt = MONTH_JAN;
        year_nxt  = FLOOR_YEAR;
        r100_nxt  = '0;
        c4_nxt    = FLOOR_C4;
      end
    end else if (cmd.step_en) begin
      if (!neg_r) begin
        if (!at_ceiling) begin
          if (day_r >= len_cur) begin
            day_nxt = DAY_FIRST;
            if (month_r >= MONTH_DEC) begin
              month_nxt = MONTH_JAN;
              year_nxt  = year_r + 1'b1;
              if (r100_r == CENT_LAST) begin
                r100_nxt = '0;
                c4_nxt   = c4_r + 1'b1;
              end else begin
                r100_nxt = r100_r + 1'b1;
              end
            end else begin
              month_nxt = month_r + 1'b1;
            end
          end else begin
            day_nxt = day_r + 1'b1;
          end
        end
      end else begin
        if (day_r > DAY_FIRST) begin
          day_nxt = day_r - 1'b1;
        end else if (month_r > MONTH_JAN) begin
          month_nxt = month_r - 1'b1;
          day_nxt   = len_prev;
        end else if (year_r <= FLOOR_YEAR) begin
          // Pinned at the floor date for the rest of the transaction.
          day_nxt   = DAY_FIRST;
          month_nxt = MONTH_JAN;
          year_nxt  = FLOOR_YEAR;
          r100_nxt  = '0;
          c4_nxt    = FLOOR_C4;
        end else begin
          day_nxt   = DAY_LAST;
          month_nxt = MONTH_DEC;
          year_nxt  = year_r - 1'b1;
          if (r100_r == 7'd0) begin
            r100_nxt = CENT_LAST;
            c4_nxt   = c4_r - 1'b1;
          end else begin
            r100_nxt = r100_r - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r   <= DAY_FIRST;
      month_r <= MONTH_JAN;
      year_r  <= FLOOR_YEAR;
      r100_r  <= '0;
      c4_r    <= FLOOR_C4;
      limit_r <= 1'b0;
    end else begin
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
      r100_r  <= r100_nxt;
      c4_r    <= c4_nxt;
      if (cmd.capture) begin
        limit_r <= 1'b0;
      end else if (cmd.step_en && sts.at_limit) begin
        limit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ld_day_r   <= in_load_day;
      ld_month_r <= in_load_month;
      ld_year_r  <= in_load_year;
      ld_q_r     <= prod[RECIP_SH +: 8];
      neg_r      <= in_mode & in_day_offset[OFFSET_BITS-1];
      cnt_r      <= in_mode ? mag : '0;
    end else if (cmd.step_en) begin
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.out_load) begin
      out_day_out   <= day_r;
      out_month_out <= month_r;
      out_year_out  <= year_r;
      out_limit_hit <= limit_r;
    end
  end

endmodule
